@@ src/lcdsr_pkg.sv @@
package lcdsr_pkg;

   // channel payloads
   typedef struct packed {
      logic [3:0] func;
      logic [7:0] value;
      logic [5:0] column;
      logic [1:0] row;
      logic       flag;
   } req_type;

   typedef struct packed {
      logic [7:0] latch_byte;
      logic [5:0] wait_ms;
      logic       last;
   } rsp_type;

   // operation codes on the request side
   localparam logic [3:0] FUNC_INIT      = 4'd0;
   localparam logic [3:0] FUNC_CHAR      = 4'd1;
   localparam logic [3:0] FUNC_COMMAND   = 4'd2;
   localparam logic [3:0] FUNC_HOME      = 4'd3;
   localparam logic [3:0] FUNC_CLEAR     = 4'd4;
   localparam logic [3:0] FUNC_GOTO      = 4'd5;
   localparam logic [3:0] FUNC_DISPLAY   = 4'd6;
   localparam logic [3:0] FUNC_CURSOR    = 4'd7;
   localparam logic [3:0] FUNC_BLINK     = 4'd8;
   localparam logic [3:0] FUNC_BACKLIGHT = 4'd9;

   // job kinds handed from front to back
   localparam logic [1:0] JOB_INIT = 2'd0;
   localparam logic [1:0] JOB_CMD  = 2'd1;
   localparam logic [1:0] JOB_CHAR = 2'd2;
   localparam logic [1:0] JOB_BL   = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       flag;
   } job_type;

   // lcd command bytes
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
   localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
   localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
   localparam logic [7:0] CMD_FUNC_1LINE = 8'h20;

   // display flag bits
   localparam logic [2:0] FLAG_DISPLAY = 3'b100;
   localparam logic [2:0] FLAG_CURSOR  = 3'b010;
   localparam logic [2:0] FLAG_BLINK   = 3'b001;

   // shift register image bits
   localparam int IMG_RS_BIT = 4;
   localparam int IMG_E_BIT  = 5;
   localparam int IMG_BL_BIT = 6;

   localparam logic [2:0] ROWS_RESET = 3'd2;

   // sequencer limits
   localparam logic [3:0] INIT_LAST_NIB = 4'd10;
   localparam logic [3:0] BYTE_LAST_NIB = 4'd1;
   localparam logic [1:0] PHASE_DATA    = 2'd0;
   localparam logic [1:0] PHASE_E_HIGH  = 2'd1;
   localparam logic [1:0] PHASE_E_LOW   = 2'd2;

   localparam logic [5:0] WAIT_POWER_UP = 6'd50;
   localparam logic [5:0] WAIT_E_PULSE  = 6'd2;

   localparam int JOB_QUEUE_DEPTH = 2;

   // nibble sent at position nib of a job; for init, data holds the function set
   function automatic logic [3:0] job_nibble(logic [1:0] kind, logic [7:0] data,
                                             logic [3:0] nib);
      logic [3:0] n;
      n = (nib == 4'd0) ? data[7:4] : data[3:0];
      if (kind == JOB_INIT) begin
         case (nib) inside
            4'd0, 4'd1: n = 4'h3;
            4'd2:       n = 4'h2;
            4'd4:       n = 4'h1;
            4'd5:       n = data[7:4];
            4'd6:       n = data[3:0];
            4'd8:       n = 4'h8;
            4'd10:      n = 4'hf;
            default:    n = 4'h0;
         endcase
      end
      return n;
   endfunction

   // wait after the enable-low latch that closes nibble nib
   function automatic logic [5:0] job_tail_wait(logic [1:0] kind, logic [3:0] nib);
      logic [5:0] w;
      w = 6'd0;
      if (kind == JOB_INIT) begin
         case (nib) inside
            4'd0:                    w = 6'd5;
            4'd1, 4'd2:              w = 6'd1;
            4'd4, 4'd6, 4'd8, 4'd10: w = 6'd15;
            default:                 w = 6'd0;
         endcase
      end else if (kind == JOB_CMD && nib == BYTE_LAST_NIB) begin
         w = 6'd5;
      end
      return w;
   endfunction

endpackage

@@ src/char_lcd_shift_register_driver_top.sv @@
// character lcd driver, 4-bit mode through an 8-bit shift register
//
// request channel: push an item (func, value, column, row, flag) while full is
// low. each item becomes a run of latch bytes, each with its wait in ms; last
// marks the final byte of the run. unknown func codes are taken and dropped.
// response channel: the oldest byte is on rsp_item while empty is low; pop
// takes it. a stalled consumer only freezes the back end; the front keeps
// taking items until the job queue fills.
// csr channel: rows_in_use, always ready; write only while the block is idle.
// the first byte of an item passes the job queue, the sequencer's job registers
// and its output register. the back-end sequencer emits one latch byte per cycle
// while the output slot is free or being popped, and a load step per job emits no
// byte. init gives 34 bytes, char 7, command/home/clear/goto/flag changes 6, backlight 1.
// reset: image and flags cleared, rows_in_use = 2, queues empty.
module char_lcd_shift_register_driver_top #(
   parameter int QUEUE_DEPTH = lcdsr_pkg::JOB_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  lcdsr_pkg::req_type req_item,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lcdsr_pkg::rsp_type rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_data
);
   import lcdsr_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   job_type q_in_item, q_out_item;

   assign req_full = q_full;

   // decode, display flags and row count
   lcdsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_item   (req_item),
      .queue_full (q_full),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .job_push   (q_push),
      .job_item   (q_in_item)
   );

   // jobs waiting for the sequencer
   lcdsr_job_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   // nibble sequencer and output register
   lcdsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job_pop   (q_pop),
      .job_item  (q_out_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

@@ src/lcdsr_front.sv @@
module lcdsr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  lcdsr_pkg::req_type  req_item,
   input  logic                queue_full,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_data,
   output logic                job_push,
   output lcdsr_pkg::job_type  job_item
);
   import lcdsr_pkg::*;

   logic [2:0] rows_ff, rows_in;
   logic [2:0] flags_ff, flags_in;
   logic       accept;
   logic       known;
   logic [2:0] mask;
   logic [2:0] new_flags;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !queue_full;

   always_comb begin
      rows_in = rows_ff;
      if (csr_valid) begin
         rows_in = csr_data;
      end
   end

   always_comb begin
      known     = 1'b1;
      mask      = FLAG_DISPLAY;
      flags_in  = flags_ff;
      job_item  = '{kind: JOB_CMD, data: 8'h00, flag: req_item.flag};
      new_flags = flags_ff;
      unique case (req_item.func) inside
         FUNC_INIT: begin
            job_item.kind = JOB_INIT;
            job_item.data = (rows_ff > 3'd1) ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;
            new_flags     = FLAG_DISPLAY;
         end
         FUNC_CHAR: begin
            job_item.kind = JOB_CHAR;
            job_item.data = req_item.value;
         end
         FUNC_COMMAND: job_item.data = req_item.value;
         FUNC_HOME:    job_item.data = CMD_HOME;
         FUNC_CLEAR:   job_item.data = CMD_CLEAR;
         FUNC_GOTO:    job_item.data = CMD_SET_DDRAM | {req_item.row, req_item.column};
         FUNC_DISPLAY, FUNC_CURSOR, FUNC_BLINK: begin
            if (req_item.func == FUNC_CURSOR) begin
               mask = FLAG_CURSOR;
            end else if (req_item.func == FUNC_BLINK) begin
               mask = FLAG_BLINK;
            end
            new_flags     = req_item.flag ? (flags_ff | mask) : (flags_ff & ~mask);
            job_item.data = CMD_DISP_CTRL | {5'd0, new_flags};
         end
         FUNC_BACKLIGHT: job_item.kind = JOB_BL;
         default: known = 1'b0;
      endcase
      job_push = accept && known;
      if (job_push) begin
         flags_in = new_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         flags_ff <= 3'd0;
      end else begin
         rows_ff  <= rows_in;
         flags_ff <= flags_in;
      end
   end

endmodule

@@ src/lcdsr_job_queue.sv @@
module lcdsr_job_queue #(
   parameter int DEPTH = lcdsr_pkg::JOB_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdsr_pkg::job_type  push_item,
   output logic                full,
   input  logic                pop,
   output lcdsr_pkg::job_type  pop_item,
   output logic                empty
);
   import lcdsr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/lcdsr_back.sv @@
module lcdsr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   output logic                job_pop,
   input  lcdsr_pkg::job_type  job_item,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output lcdsr_pkg::rsp_type  rsp_item
);
   import lcdsr_pkg::*;

   logic        busy_ff, busy_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic        flag_ff, flag_in;
   logic        pre_ff, pre_in;
   logic        tail_ff, tail_in;
   logic [3:0]  nib_ff, nib_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  image_ff, image_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        advance;
   logic        emit;
   rsp_type     emit_item;
   logic [3:0]  cur_nib;
   logic [3:0]  last_nib;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign advance   = busy_ff && (!out_valid_ff || rsp_pop);
   assign cur_nib   = job_nibble(kind_ff, data_ff, nib_ff);
   assign last_nib  = (kind_ff == JOB_INIT) ? INIT_LAST_NIB : BYTE_LAST_NIB;

   // one latch byte per cycle while a job runs and the output slot is free or being popped
   always_comb begin
      busy_in   = busy_ff;
      kind_in   = kind_ff;
      data_in   = data_ff;
      flag_in   = flag_ff;
      pre_in    = pre_ff;
      tail_in   = tail_ff;
      nib_in    = nib_ff;
      phase_in  = phase_ff;
      image_in  = image_ff;
      job_pop   = 1'b0;
      emit      = 1'b0;
      emit_item = '{latch_byte: 8'h00, wait_ms: 6'd0, last: 1'b0};
      if (!busy_ff) begin
         if (!job_empty) begin
            job_pop  = 1'b1;
            busy_in  = 1'b1;
            kind_in  = job_item.kind;
            data_in  = job_item.data;
            flag_in  = job_item.flag;
            pre_in   = (job_item.kind == JOB_INIT);
            tail_in  = 1'b0;
            nib_in   = 4'd0;
            phase_in = PHASE_DATA;
         end
      end else if (advance) begin
         emit = 1'b1;
         if (kind_ff == JOB_BL) begin
            image_in[IMG_BL_BIT] = flag_ff;
            emit_item.last       = 1'b1;
            busy_in              = 1'b0;
         end else if (pre_ff) begin
            // power-up latch of all zeros, image untouched
            emit_item.wait_ms = WAIT_POWER_UP;
            pre_in            = 1'b0;
         end else if (tail_ff) begin
            image_in[IMG_RS_BIT] = 1'b0;
            emit_item.last       = 1'b1;
            tail_in              = 1'b0;
            busy_in              = 1'b0;
         end else begin
            unique case (phase_ff)
               PHASE_DATA: begin
                  image_in[3:0] = cur_nib;
                  if (kind_ff == JOB_CHAR && nib_ff == 4'd0) begin
                     image_in[IMG_RS_BIT] = 1'b1;
                  end
                  phase_in = PHASE_E_HIGH;
               end
               PHASE_E_HIGH: begin
                  image_in[IMG_E_BIT] = 1'b1;
                  emit_item.wait_ms   = WAIT_E_PULSE;
                  phase_in            = PHASE_E_LOW;
               end
               PHASE_E_LOW: begin
                  image_in[IMG_E_BIT] = 1'b0;
                  emit_item.wait_ms   = job_tail_wait(kind_ff, nib_ff);
                  phase_in            = PHASE_DATA;
                  if (nib_ff == last_nib) begin
                     if (kind_ff == JOB_CHAR) begin
                        tail_in = 1'b1;
                     end else begin
                        emit_item.last = 1'b1;
                        busy_in        = 1'b0;
                     end
                  end else begin
                     nib_in = nib_ff + 4'd1;
                  end
               end
               default: phase_in = PHASE_DATA;
            endcase
         end
         if (!pre_ff) begin
            emit_item.latch_byte = image_in;
         end
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = emit_item;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pre_ff       <= 1'b0;
         tail_ff      <= 1'b0;
         nib_ff       <= 4'd0;
         phase_ff     <= PHASE_DATA;
         image_ff     <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pre_ff       <= pre_in;
         tail_ff      <= tail_in;
         nib_ff       <= nib_in;
         phase_ff     <= phase_in;
         image_ff     <= image_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      flag_ff <= flag_in;
      out_ff  <= out_in;
   end

`ifndef SYNTH
   // a job is taken only when the sequencer is free, and it then runs
   assert property (@(posedge clock) disable iff (reset) job_pop |-> !busy_ff ##1 busy_ff)
      else $error("job taken while sequencer busy");

   // nibble index stays inside the job's script
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> nib_ff <= last_nib)
      else $error("nibble index past end of job");

   // the trailing rs-clear latch belongs to character jobs only
   assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> (busy_ff && kind_ff == JOB_CHAR && phase_ff == PHASE_DATA))
      else $error("trailing latch outside a character job");

   // enable bit never stays high once a job is done
   assert property (@(posedge clock) disable iff (reset) !busy_ff |-> !image_ff[IMG_E_BIT])
      else $error("enable left high between jobs");
`endif

endmodule
